// ----- rtl/core/pgse_pkg.sv -----
// ----------------------------------------------------------------------------
// pgse_pkg - shared types, constants and helpers
// Queue entry, sequencer states and byte tables for the stored PNG encoder.
// ----------------------------------------------------------------------------
package pgse_pkg;

  localparam int unsigned DIM_BITS_DEF   = 13;
  localparam int unsigned BLOCK_MAX_DEF  = 65535;
  localparam int unsigned EFF_W          = 13;   // saturated dimension, 1..4096
  localparam int unsigned RAW_W          = 25;   // h * (w + 1)
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned MAX_WORDS      = 50;   // words kept per pixel
  localparam int unsigned WIDTH_RESET    = 160;
  localparam int unsigned HEIGHT_RESET   = 144;
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD      = 17'd65521;
  localparam logic [7:0]  ZLIB_CMF       = 8'h78;
  localparam logic [7:0]  ZLIB_FLG       = 8'h01;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;      // first pixel of an image: headers go out first
    logic       row_start;  // filter byte goes out first
    logic       last;       // last pixel: trailer follows
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SIG, ST_IHDR_LEN, ST_IHDR_TAG, ST_IHDR_BODY, ST_IHDR_CRC,
    ST_IDAT_LEN, ST_IDAT_TAG, ST_ZHDR, ST_BHDR, ST_FILT, ST_PIX,
    ST_ADLER, ST_IDAT_CRC, ST_IEND_LEN, ST_IEND_TAG, ST_IEND_CRC
  } seq_state_e;

  typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_DIV, DV_FIN} div_state_e;

  typedef enum logic [1:0] {TAG_IHDR, TAG_IDAT, TAG_IEND} tag_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4E;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0D;
      3'd5: r = 8'h0A;
      3'd6: r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tag_byte(input tag_e t, input logic [1:0] i);
    logic [31:0] w;
    unique case (t)
      TAG_IHDR: w = 32'h49484452;
      TAG_IDAT: w = 32'h49444154;
      default:  w = 32'h49454E44;
    endcase
    return w[8*(3-i) +: 8];
  endfunction

  // big-endian byte i of a 32-bit word
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
    return v[8*(3-i) +: 8];
  endfunction

endpackage

// ----- rtl/core/pgse_front.sv -----
// ----------------------------------------------------------------------------
// pgse_front - pixel intake
// Tracks column and row, marks image start, row start and last pixel.
// ----------------------------------------------------------------------------
module pgse_front import pgse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [EFF_W-1:0] eff_w_i,
  input  logic [EFF_W-1:0] eff_h_i,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [7:0]       s_pix_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  logic             phase_q, phase_d;
  logic [EFF_W-1:0] col_q, col_d, row_q, row_d;
  logic [EFF_W-1:0] col_nx, row_nx;
  logic             wrap, last;

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  assign col_nx = col_q + 1'b1;
  assign row_nx = row_q + 1'b1;
  assign wrap   = col_nx >= eff_w_i;
  assign last   = wrap && (row_nx >= eff_h_i);

  assign q_entry_o = '{pix: s_pix_i, first: !phase_q, row_start: (col_q == '0), last: last};

  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    if (clear_i) begin
      phase_d = 1'b0;
      col_d   = '0;
      row_d   = '0;
    end else if (q_push_o) begin
      phase_d = !last;
      col_d   = wrap ? '0 : col_nx;
      row_d   = last ? '0 : (wrap ? row_nx : row_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

// ----- rtl/core/pgse_queue.sv -----
// ----------------------------------------------------------------------------
// pgse_queue - short entry queue
// Register FIFO between intake and byte sequencer.
// ----------------------------------------------------------------------------
module pgse_queue import pgse_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  entry_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// ----- rtl/core/pgse_lenc.sv -----
// ----------------------------------------------------------------------------
// pgse_lenc - IDAT length unit
// raw = h*(w+1), stored block count by reciprocal multiplication, IDAT length.
// ----------------------------------------------------------------------------
module pgse_lenc import pgse_pkg::*; #(
  parameter int unsigned STORED_BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [EFF_W-1:0] eff_w_i,
  input  logic [EFF_W-1:0] eff_h_i,
  output logic             done_o,
  output logic [RAW_W-1:0] raw_len_o,
  output logic [31:0]      idat_len_o
);

  // ceil(raw / max) = ((raw + max - 1) * RCP) >> SH, exact for a 26-bit dividend
  localparam int unsigned SH    = RAW_W + 1 + $clog2(STORED_BLOCK_MAX);
  localparam int unsigned RCP_W = RAW_W + 3;
  localparam int unsigned PW    = RAW_W + 1 + RCP_W;
  localparam logic [63:0] RCP_L = ((64'd1 << SH) + 64'(STORED_BLOCK_MAX) - 64'd1) /
                                  64'(STORED_BLOCK_MAX);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  div_state_e       st_q, st_d;
  logic [EFF_W-1:0] w1_q, w1_d, h_q, h_d;
  logic [RAW_W-1:0] raw_q, raw_d, quo_q, quo_d;
  logic             done_q, done_d;
  logic [31:0]      len_q, len_d;
  logic [RAW_W:0]   xsum;
  logic [PW-1:0]    prod;

  assign xsum = {1'b0, raw_q} + (RAW_W+1)'(STORED_BLOCK_MAX - 1);
  assign prod = PW'(xsum) * PW'(RCP);

  // next state
  always_comb begin
    st_d = st_q;
    if (start_i) begin
      st_d = DV_MUL;
    end else begin
      unique case (st_q)
        DV_IDLE: st_d = DV_IDLE;
        DV_MUL:  st_d = DV_DIV;
        DV_DIV:  st_d = DV_FIN;
        default: st_d = DV_IDLE;
      endcase
    end
  end

  // datapath
  always_comb begin
    w1_d = w1_q; h_d = h_q; raw_d = raw_q; quo_d = quo_q;
    done_d = done_q; len_d = len_q;
    if (start_i) begin
      w1_d   = eff_w_i + 1'b1;
      h_d    = eff_h_i;
      done_d = 1'b0;
    end else begin
      unique case (st_q)
        DV_MUL: raw_d = RAW_W'(w1_q) * RAW_W'(h_q);
        DV_DIV: quo_d = RAW_W'(prod >> SH);
        DV_FIN: begin
          len_d  = 32'(raw_q) + (32'(quo_q) << 2) + 32'(quo_q) + 32'd6;
          done_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q  <= w1_d;
    h_q   <= h_d;
    raw_q <= raw_d;
    quo_q <= quo_d;
    len_q <= len_d;
  end

  assign done_o     = done_q;
  assign raw_len_o  = raw_q;
  assign idat_len_o = len_q;

endmodule

// ----- rtl/core/pgse_back.sv -----
// ----------------------------------------------------------------------------
// pgse_back - byte sequencer
// Walks headers, stored blocks and trailer; CRC-32 and Adler-32 per word.
// ----------------------------------------------------------------------------
module pgse_back import pgse_pkg::*; #(
  parameter int unsigned STORED_BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [EFF_W-1:0] eff_w_i,
  input  logic [EFF_W-1:0] eff_h_i,
  input  logic             q_empty_i,
  input  entry_t           q_head_i,
  output logic             q_pop_o,
  output logic             len_start_o,
  input  logic             len_done_i,
  input  logic [RAW_W-1:0] raw_len_i,
  input  logic [31:0]      idat_len_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [7:0]       m_byte_o,
  output logic             m_run_last_o,
  output logic             m_image_end_o
);

  localparam logic [RAW_W-1:0] SBM = RAW_W'(STORED_BLOCK_MAX);

  seq_state_e       st_q, st_d;
  logic [4:0]       idx_q, idx_d;
  logic [31:0]      crc_q, crc_d;
  logic [15:0]      lo_q, lo_d, hi_q, hi_d;
  logic [15:0]      blk_q, blk_d;
  logic [RAW_W-1:0] raw_q, raw_d;
  logic             ret_filt_q, ret_filt_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q, ol_d, oe_q, oe_d;

  logic        adv;
  logic        emit, crc_en, crc_init, raw_emit, entry_end, file_end, dispatch;
  logic [7:0]  b;
  logic        need_hdr, blk_final;
  logic [15:0] blk_n;
  logic [31:0] crc_in, crc_out;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_n, hi_n;

  assign adv       = !ov_q || m_ready_i;
  assign need_hdr  = (blk_q == '0) && (raw_q != '0);
  assign blk_final = !(raw_q > SBM);
  assign blk_n     = blk_final ? raw_q[15:0] : SBM[15:0];

  // next state
  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    ret_filt_d = ret_filt_q;
    if (adv) begin
      unique case (st_q)
        ST_IDLE: begin
          idx_d = '0;
          if (!q_empty_i) begin
            if (q_head_i.first)          st_d = ST_SIG;
            else if (q_head_i.row_start) st_d = ST_FILT;
            else                         st_d = ST_PIX;
          end
        end
        ST_SIG: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd7) begin st_d = ST_IHDR_LEN; idx_d = '0; end
        end
        ST_IHDR_LEN: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IHDR_TAG; idx_d = '0; end
        end
        ST_IHDR_TAG: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IHDR_BODY; idx_d = '0; end
        end
        ST_IHDR_BODY: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd12) begin st_d = ST_IHDR_CRC; idx_d = '0; end
        end
        ST_IHDR_CRC: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IDAT_LEN; idx_d = '0; end
        end
        ST_IDAT_LEN: begin
          if (len_done_i) begin
            idx_d = idx_q + 1'b1;
            if (idx_q == 5'd3) begin st_d = ST_IDAT_TAG; idx_d = '0; end
          end
        end
        ST_IDAT_TAG: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_ZHDR; idx_d = '0; end
        end
        ST_ZHDR: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd1) begin
            idx_d = '0;
            st_d  = q_head_i.row_start ? ST_FILT : ST_PIX;
          end
        end
        ST_BHDR: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd4) begin
            idx_d = '0;
            st_d  = ret_filt_q ? ST_FILT : ST_PIX;
          end
        end
        ST_FILT: begin
          if (need_hdr) begin
            st_d = ST_BHDR; idx_d = '0; ret_filt_d = 1'b1;
          end else begin
            st_d = ST_PIX;
          end
        end
        ST_PIX: begin
          if (need_hdr) begin
            st_d = ST_BHDR; idx_d = '0; ret_filt_d = 1'b0;
          end else begin
            st_d = q_head_i.last ? ST_ADLER : ST_IDLE;
            idx_d = '0;
          end
        end
        ST_ADLER: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IDAT_CRC; idx_d = '0; end
        end
        ST_IDAT_CRC: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IEND_LEN; idx_d = '0; end
        end
        ST_IEND_LEN: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IEND_TAG; idx_d = '0; end
        end
        ST_IEND_TAG: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IEND_CRC; idx_d = '0; end
        end
        ST_IEND_CRC: begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 5'd3) begin st_d = ST_IDLE; idx_d = '0; end
        end
        default: st_d = ST_IDLE;
      endcase
    end
  end

  // word selection
  always_comb begin
    emit = 1'b0; crc_en = 1'b0; crc_init = 1'b0; raw_emit = 1'b0;
    entry_end = 1'b0; file_end = 1'b0; dispatch = 1'b0; b = 8'd0;
    unique case (st_q)
      ST_IDLE: dispatch = !q_empty_i;
      ST_SIG: begin emit = 1'b1; b = sig_byte(idx_q[2:0]); end
      ST_IHDR_LEN: begin emit = 1'b1; b = be_byte(32'd13, idx_q[1:0]); end
      ST_IHDR_TAG: begin
        emit = 1'b1; crc_en = 1'b1; crc_init = (idx_q == '0);
        b = tag_byte(TAG_IHDR, idx_q[1:0]);
      end
      ST_IHDR_BODY: begin
        emit = 1'b1; crc_en = 1'b1;
        if (idx_q < 5'd4)       b = be_byte(32'(eff_w_i), idx_q[1:0]);
        else if (idx_q < 5'd8)  b = be_byte(32'(eff_h_i), idx_q[1:0]);
        else if (idx_q == 5'd8) b = 8'd8;   // bit depth
        else                    b = 8'd0;   // gray, methods, no interlace
      end
      ST_IHDR_CRC, ST_IDAT_CRC, ST_IEND_CRC: begin
        emit = 1'b1; b = be_byte(~crc_q, idx_q[1:0]);
        if (st_q == ST_IEND_CRC && idx_q == 5'd3) begin
          file_end = 1'b1; entry_end = 1'b1;
        end
      end
      ST_IDAT_LEN: begin
        emit = len_done_i; b = be_byte(idat_len_i, idx_q[1:0]);
      end
      ST_IDAT_TAG: begin
        emit = 1'b1; crc_en = 1'b1; crc_init = (idx_q == '0);
        b = tag_byte(TAG_IDAT, idx_q[1:0]);
      end
      ST_ZHDR: begin
        emit = 1'b1; crc_en = 1'b1; b = (idx_q == '0) ? ZLIB_CMF : ZLIB_FLG;
      end
      ST_BHDR: begin
        emit = 1'b1; crc_en = 1'b1;
        unique case (idx_q[2:0])
          3'd0:    b = {7'd0, blk_final};
          3'd1:    b = blk_n[7:0];
          3'd2:    b = blk_n[15:8];
          3'd3:    b = ~blk_n[7:0];
          default: b = ~blk_n[15:8];
        endcase
      end
      ST_FILT: begin
        emit = !need_hdr; crc_en = 1'b1; raw_emit = !need_hdr; b = 8'd0;
      end
      ST_PIX: begin
        emit = !need_hdr; crc_en = 1'b1; raw_emit = !need_hdr; b = q_head_i.pix;
        entry_end = !need_hdr && !q_head_i.last;
      end
      ST_ADLER: begin
        emit = 1'b1; crc_en = 1'b1; b = be_byte({hi_q, lo_q}, idx_q[1:0]);
      end
      ST_IEND_LEN: begin emit = 1'b1; b = 8'd0; end
      ST_IEND_TAG: begin
        emit = 1'b1; crc_en = 1'b1; crc_init = (idx_q == '0);
        b = tag_byte(TAG_IEND, idx_q[1:0]);
      end
      default: ;
    endcase
  end

  assign crc_in  = crc_init ? '1 : crc_q;
  assign crc_out = crc_byte(crc_in, b);
  assign lo_sum  = 17'(lo_q) + 17'(b);
  assign lo_n    = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
  assign hi_sum  = 17'(hi_q) + 17'(lo_n);
  assign hi_n    = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

  assign q_pop_o     = adv && entry_end;
  assign len_start_o = adv && dispatch && q_head_i.first;

  // registers of the datapath
  always_comb begin
    crc_d = crc_q; lo_d = lo_q; hi_d = hi_q; blk_d = blk_q; raw_d = raw_q;
    cnt_d = cnt_q; ov_d = ov_q; ob_d = ob_q; ol_d = ol_q; oe_d = oe_q;
    if (adv) begin
      ov_d = emit && (cnt_q < 6'(MAX_WORDS));
      ob_d = b;
      ol_d = entry_end || (cnt_q == 6'(MAX_WORDS - 1));
      oe_d = file_end;
      if (dispatch) cnt_d = '0;
      else if (emit && cnt_q < 6'(MAX_WORDS)) cnt_d = cnt_q + 1'b1;
      if (emit && crc_en) crc_d = crc_out;
      if (dispatch && q_head_i.first) begin
        lo_d = 16'd1;
        hi_d = '0;
      end
      if (st_q == ST_ZHDR && idx_q == 5'd1) begin
        raw_d = raw_len_i;
        blk_d = '0;
      end
      if (st_q == ST_BHDR && idx_q == 5'd4) blk_d = blk_n;
      if (raw_emit) begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (blk_q != '0) blk_d = blk_q - 1'b1;
        if (raw_q != '0) raw_d = raw_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      idx_q      <= '0;
      ret_filt_q <= 1'b0;
      cnt_q      <= '0;
      ov_q       <= 1'b0;
      crc_q      <= '1;
      lo_q       <= 16'd1;
      hi_q       <= '0;
      blk_q      <= '0;
      raw_q      <= '0;
    end else begin
      st_q       <= st_d;
      idx_q      <= idx_d;
      ret_filt_q <= ret_filt_d;
      cnt_q      <= cnt_d;
      ov_q       <= ov_d;
      crc_q      <= crc_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      blk_q      <= blk_d;
      raw_q      <= raw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    oe_q <= oe_d;
  end

  assign m_valid_o     = ov_q;
  assign m_byte_o      = ob_q;
  assign m_run_last_o  = ol_q;
  assign m_image_end_o = oe_q;

endmodule

// ----- rtl/core/png_gray_stored_encoder.sv -----
// ----------------------------------------------------------------------------
// png_gray_stored_encoder - grayscale pixels in, PNG file bytes out
// Stored (uncompressed) zlib stream inside a single IDAT chunk.
// ----------------------------------------------------------------------------
// Start: the first pixel of an image passes the queue, the sequencer state
//   and the output register before the first word; the IDAT length comes
//   from a multiply unit started at dispatch, ready long before it is due.
// Throughput: one word per cycle from the output register unless m_axis_tready
//   stalls; a pixel passes the idle and pixel states, plus filter at row start.
// Reset: control state cleared, size registers at 160 x 144, next pixel
//   opens a new image. No clearing pass.
module png_gray_stored_encoder import pgse_pkg::*; #(
  parameter int unsigned DIM_BITS         = DIM_BITS_DEF,
  parameter int unsigned STORED_BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_BITS-1:0]  cfg_data_i,
  // pixel stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,    // [7:0] pixel_value
  // file byte stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,    // [7:0] out_byte
  output logic                 m_axis_tlast,    // run_last
  output logic                 m_axis_tuser     // [0] image_end
);

  logic [DIM_BITS-1:0] width_q, height_q;
  logic [15:0]         wx, hx;
  logic [EFF_W-1:0]    eff_w, eff_h;
  logic                cfg_hit;

  entry_t           push_entry, head;
  logic             q_push, q_full, q_pop, q_empty;
  logic             len_start, len_done;
  logic [RAW_W-1:0] raw_len;
  logic [31:0]      idat_len;

  // size registers; any write to them abandons a half-sent image
  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i &&
                       (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(WIDTH_RESET);
      height_q <= DIM_BITS'(HEIGHT_RESET);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_index_i == REG_HEIGHT) height_q <= cfg_data_i;
    end
  end

  // saturate into 2..4096 and 1..4096; IHDR carries these
  assign wx = 16'(width_q);
  assign hx = 16'(height_q);
  assign eff_w = (wx < 16'd2) ? EFF_W'(2) : (wx > 16'd4096) ? EFF_W'(4096) : wx[EFF_W-1:0];
  assign eff_h = (hx < 16'd1) ? EFF_W'(1) : (hx > 16'd4096) ? EFF_W'(4096) : hx[EFF_W-1:0];

  pgse_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_hit),
    .eff_w_i   (eff_w),
    .eff_h_i   (eff_h),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_pix_i   (s_axis_tdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  // classified pixels wait here while the sequencer is busy with headers
  pgse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  pgse_lenc #(.STORED_BLOCK_MAX(STORED_BLOCK_MAX)) u_lenc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (len_start),
    .eff_w_i    (eff_w),
    .eff_h_i    (eff_h),
    .done_o     (len_done),
    .raw_len_o  (raw_len),
    .idat_len_o (idat_len)
  );

  pgse_back #(.STORED_BLOCK_MAX(STORED_BLOCK_MAX)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_w_i       (eff_w),
    .eff_h_i       (eff_h),
    .q_empty_i     (q_empty),
    .q_head_i      (head),
    .q_pop_o       (q_pop),
    .len_start_o   (len_start),
    .len_done_i    (len_done),
    .raw_len_i     (raw_len),
    .idat_len_i    (idat_len),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_byte_o      (m_axis_tdata),
    .m_run_last_o  (m_axis_tlast),
    .m_image_end_o (m_axis_tuser)
  );

endmodule
